@@ rtl/rmbc_pkg.sv @@
// Shared types and constants for the recurring-minimum Bloom counter.
// No dependencies; imported by the lane, merge and top-level modules.
package rmbc_pkg;

  // Hash positions per word, fixed by the port list
  localparam int HASH_COUNT = 4;
  localparam int LANE_W     = $clog2(HASH_COUNT);
  localparam int CNT_W      = $clog2(HASH_COUNT + 1);
  localparam int WIDE_W     = 32;
  localparam int EST_W      = 16;
  localparam int PIDX_W     = 10;
  localparam int SIDX_W     = 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PWRITE,
    ST_MERGE,
    ST_DECIDE,
    ST_SWRITE
  } state_t;

  // Per-lane control from the sequencer
  typedef struct packed {
    logic capture_idx;
    logic load;
    logic wr;
  } lane_ctl_t;

endpackage

@@ rtl/rmbc_lane.sv @@
// One hash lane: holds a wrapped index and the counter value at that index.
// Loads from the memory read port and snoops writes to stay current. Uses rmbc_pkg.
module rmbc_lane
  import rmbc_pkg::*;
#(
  parameter int W  = 8,
  parameter int AW = 10
) (
  input  logic          clk,
  input  lane_ctl_t     ctl,
  input  logic [AW-1:0] idx_in,
  input  logic [W-1:0]  rd_data,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  output logic [AW-1:0] idx,
  output logic [W-1:0]  val
);

  logic [AW-1:0] idx_r;
  logic [W-1:0]  val_r;

  // Hold index; take read data, or follow any write that hits our cell
  always_ff @(posedge clk) begin
    if (ctl.capture_idx) begin
      idx_r <= idx_in;
    end
    if (ctl.load) begin
      val_r <= rd_data;
    end else if (ctl.wr && (wr_addr == idx_r)) begin
      val_r <= wr_data;
    end
  end

  assign idx = idx_r;
  assign val = val_r;

endmodule

@@ rtl/rmbc_merge.sv @@
// Merging stage: primary minimum with recurrence flag, and secondary minimum.
// Results are registered. Uses rmbc_pkg.
module rmbc_merge
  import rmbc_pkg::*;
#(
  parameter int PW = 8,
  parameter int SW = 16
) (
  input  logic          clk,
  input  logic [PW-1:0] p_val [HASH_COUNT],
  input  logic [SW-1:0] s_val [HASH_COUNT],
  output logic [PW-1:0] pmin,
  output logic          recurs,
  output logic [SW-1:0] smin
);

  logic [PW-1:0] pmin_r, pmin_c;
  logic          recurs_r, recurs_c;
  logic [SW-1:0] smin_r, smin_c;

  // Scan lanes in order: strictly smaller resets recurrence, equal sets it
  always_comb begin
    pmin_c   = p_val[0];
    recurs_c = 1'b0;
    smin_c   = s_val[0];
    for (int k = 1; k < HASH_COUNT; k++) begin
      if (p_val[k] < pmin_c) begin
        pmin_c   = p_val[k];
        recurs_c = 1'b0;
      end else if (p_val[k] == pmin_c) begin
        recurs_c = 1'b1;
      end
      if (s_val[k] < smin_c) begin
        smin_c = s_val[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    pmin_r   <= pmin_c;
    recurs_r <= recurs_c;
    smin_r   <= smin_c;
  end

  assign pmin   = pmin_r;
  assign recurs = recurs_r;
  assign smin   = smin_r;

endmodule

@@ rtl/recurring_minimum_bloom_counter.sv @@
// Recurring-minimum Bloom counter. Query: reads each lane's cells in both tables, merges, returns an estimate;
// insert: reads, increments the primary cells, then updates the secondary table when the minimum does not recur.
// One word at a time; the single port of each counter memory sets the pace.
// Reset: synchronous active-low; a clearing pass zeroes both memories before in_ready rises.
module recurring_minimum_bloom_counter
  import rmbc_pkg::*;
#(
  parameter int PRIMARY_CELLS   = 1024,
  parameter int SECONDARY_CELLS = 256,
  parameter int PRIMARY_WIDTH   = 8,
  parameter int SECONDARY_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [PIDX_W-1:0] in_primary_index_0,
  input  logic [PIDX_W-1:0] in_primary_index_1,
  input  logic [PIDX_W-1:0] in_primary_index_2,
  input  logic [PIDX_W-1:0] in_primary_index_3,
  input  logic [SIDX_W-1:0] in_secondary_index_0,
  input  logic [SIDX_W-1:0] in_secondary_index_1,
  input  logic [SIDX_W-1:0] in_secondary_index_2,
  input  logic [SIDX_W-1:0] in_secondary_index_3,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [EST_W-1:0]  out_estimate,
  output logic              out_minimum_recurs,
  output logic              out_from_secondary
);

  localparam int PAW = $clog2(PRIMARY_CELLS);
  localparam int SAW = $clog2(SECONDARY_CELLS);
  localparam int PW  = PRIMARY_WIDTH;
  localparam int SW  = SECONDARY_WIDTH;
  localparam int CLR_DEPTH = (PRIMARY_CELLS > SECONDARY_CELLS) ? PRIMARY_CELLS
                                                               : SECONDARY_CELLS;
  localparam int CCW = $clog2(CLR_DEPTH);

  // Wrap an index modulo the cell count by shifted compare-and-subtract
  function automatic logic [PAW-1:0] wrap_p(input logic [PIDX_W-1:0] x);
    logic [WIDE_W-1:0] r;
    r = WIDE_W'(x);
    for (int b = 6; b >= 0; b--) begin
      if (r >= (WIDE_W'(PRIMARY_CELLS) << b)) begin
        r = r - (WIDE_W'(PRIMARY_CELLS) << b);
      end
    end
    return r[PAW-1:0];
  endfunction

  function automatic logic [SAW-1:0] wrap_s(input logic [SIDX_W-1:0] x);
    logic [WIDE_W-1:0] r;
    r = WIDE_W'(x);
    for (int b = 6; b >= 0; b--) begin
      if (r >= (WIDE_W'(SECONDARY_CELLS) << b)) begin
        r = r - (WIDE_W'(SECONDARY_CELLS) << b);
      end
    end
    return r[SAW-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CCW-1:0]   clr_r;
  logic             op_r;
  logic             ld_vld_r;
  logic [LANE_W-1:0] ld_tag_r;
  logic [WIDE_W-1:0] delta_r;
  logic             out_valid_r;
  logic [EST_W-1:0] est_r;
  logic             recurs_out_r, fsec_r;

  logic in_acc, rd_issue, pw_act, sw_act, load_out, clr_act;
  logic [LANE_W-1:0] lane_sel;

  logic [PAW-1:0] p_idx_in [HASH_COUNT];
  logic [SAW-1:0] s_idx_in [HASH_COUNT];
  logic [PAW-1:0] p_idx    [HASH_COUNT];
  logic [SAW-1:0] s_idx    [HASH_COUNT];
  logic [PW-1:0]  p_val    [HASH_COUNT];
  logic [SW-1:0]  s_val    [HASH_COUNT];
  lane_ctl_t      p_ctl    [HASH_COUNT];
  lane_ctl_t      s_ctl    [HASH_COUNT];

  logic [PW-1:0] pmin;
  logic [SW-1:0] smin;
  logic          recurs;

  // Memory ports
  logic [PW-1:0]  p_mem [PRIMARY_CELLS];
  logic [SW-1:0]  s_mem [SECONDARY_CELLS];
  logic           p_we, s_we;
  logic [PAW-1:0] p_addr, p_waddr;
  logic [SAW-1:0] s_addr, s_waddr;
  logic [PW-1:0]  p_wdata, p_rdata_r, p_inc;
  logic [SW-1:0]  s_wdata, s_rdata_r, s_add;
  logic [WIDE_W:0] s_sum;

  assign in_acc   = in_valid && in_ready;
  assign lane_sel = cnt_r[LANE_W-1:0];

  assign p_idx_in[0] = wrap_p(in_primary_index_0);
  assign p_idx_in[1] = wrap_p(in_primary_index_1);
  assign p_idx_in[2] = wrap_p(in_primary_index_2);
  assign p_idx_in[3] = wrap_p(in_primary_index_3);
  assign s_idx_in[0] = wrap_s(in_secondary_index_0);
  assign s_idx_in[1] = wrap_s(in_secondary_index_1);
  assign s_idx_in[2] = wrap_s(in_secondary_index_2);
  assign s_idx_in[3] = wrap_s(in_secondary_index_3);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_r == CCW'(CLR_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ: begin
        if (cnt_r == CNT_W'(HASH_COUNT)) begin
          state_nxt = (op_r == OP_INSERT) ? ST_PWRITE : ST_MERGE;
        end
      end
      ST_PWRITE: if (cnt_r == CNT_W'(HASH_COUNT - 1)) state_nxt = ST_MERGE;
      ST_MERGE:  state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (op_r == OP_QUERY) begin
          if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
        end else begin
          state_nxt = recurs ? ST_IDLE : ST_SWRITE;
        end
      end
      ST_SWRITE: if (cnt_r == CNT_W'(HASH_COUNT - 1)) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    rd_issue = 1'b0;
    pw_act   = 1'b0;
    sw_act   = 1'b0;
    load_out = 1'b0;
    clr_act  = 1'b0;
    case (state_r)
      ST_CLEAR:  clr_act  = 1'b1;
      ST_IDLE:   in_ready = 1'b1;
      ST_READ:   rd_issue = (cnt_r < CNT_W'(HASH_COUNT));
      ST_PWRITE: pw_act   = 1'b1;
      ST_DECIDE: load_out = (op_r == OP_QUERY) && (!out_valid_r || out_ready);
      ST_SWRITE: sw_act   = 1'b1;
      default:   clr_act  = 1'b0;
    endcase
  end

  assign cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + CNT_W'(1);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      ld_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ld_vld_r <= rd_issue;
      if (clr_act) begin
        clr_r <= clr_r + CCW'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ld_tag_r <= lane_sel;
    if (in_acc) begin
      op_r <= in_opcode;
    end
    if (state_r == ST_DECIDE) begin
      delta_r <= (smin != '0) ? WIDE_W'(1) : WIDE_W'(pmin);
    end
    if (load_out) begin
      recurs_out_r <= recurs;
      if (recurs) begin
        est_r  <= (WIDE_W'(pmin) > WIDE_W'({EST_W{1'b1}})) ? {EST_W{1'b1}} : EST_W'(pmin);
        fsec_r <= 1'b0;
      end else if (smin != '0) begin
        est_r  <= (WIDE_W'(smin) > WIDE_W'({EST_W{1'b1}})) ? {EST_W{1'b1}} : EST_W'(smin);
        fsec_r <= 1'b1;
      end else begin
        est_r  <= (WIDE_W'(pmin) > WIDE_W'({EST_W{1'b1}})) ? {EST_W{1'b1}} : EST_W'(pmin);
        fsec_r <= 1'b0;
      end
    end
  end

  // Saturating updates from the selected lane
  assign p_inc = (p_val[lane_sel] == {PW{1'b1}}) ? p_val[lane_sel] : p_val[lane_sel] + PW'(1);
  assign s_sum = (WIDE_W + 1)'(s_val[lane_sel]) + (WIDE_W + 1)'(delta_r);
  assign s_add = (s_sum > (WIDE_W + 1)'({SW{1'b1}})) ? {SW{1'b1}} : s_sum[SW-1:0];

  // Memory write and address selection
  always_comb begin
    p_we    = pw_act;
    p_waddr = p_idx[lane_sel];
    p_wdata = p_inc;
    s_we    = sw_act;
    s_waddr = s_idx[lane_sel];
    s_wdata = s_add;
    if (clr_act) begin
      p_we    = ((CCW + 1)'(clr_r) < (CCW + 1)'(PRIMARY_CELLS));
      p_waddr = clr_r[PAW-1:0];
      p_wdata = '0;
      s_we    = ((CCW + 1)'(clr_r) < (CCW + 1)'(SECONDARY_CELLS));
      s_waddr = clr_r[SAW-1:0];
      s_wdata = '0;
    end
  end

  assign p_addr = p_we ? p_waddr : p_idx[lane_sel];
  assign s_addr = s_we ? s_waddr : s_idx[lane_sel];

  // Primary counter memory, single port
  always_ff @(posedge clk) begin
    if (p_we) begin
      p_mem[p_addr] <= p_wdata;
    end
    p_rdata_r <= p_mem[p_addr];
  end

  // Secondary counter memory, single port
  always_ff @(posedge clk) begin
    if (s_we) begin
      s_mem[s_addr] <= s_wdata;
    end
    s_rdata_r <= s_mem[s_addr];
  end

  // Hash lanes
  for (genvar k = 0; k < HASH_COUNT; k++) begin : g_lane
    assign p_ctl[k] = '{capture_idx: in_acc,
                        load: ld_vld_r && (ld_tag_r == LANE_W'(k)),
                        wr: pw_act};
    assign s_ctl[k] = '{capture_idx: in_acc,
                        load: ld_vld_r && (ld_tag_r == LANE_W'(k)),
                        wr: sw_act};

    rmbc_lane #(.W(PW), .AW(PAW)) u_plane (
      .clk     (clk),
      .ctl     (p_ctl[k]),
      .idx_in  (p_idx_in[k]),
      .rd_data (p_rdata_r),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .idx     (p_idx[k]),
      .val     (p_val[k])
    );

    rmbc_lane #(.W(SW), .AW(SAW)) u_slane (
      .clk     (clk),
      .ctl     (s_ctl[k]),
      .idx_in  (s_idx_in[k]),
      .rd_data (s_rdata_r),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .idx     (s_idx[k]),
      .val     (s_val[k])
    );
  end

  // Combine lane values
  rmbc_merge #(.PW(PW), .SW(SW)) u_merge (
    .clk    (clk),
    .p_val  (p_val),
    .s_val  (s_val),
    .pmin   (pmin),
    .recurs (recurs),
    .smin   (smin)
  );

  assign out_valid          = out_valid_r;
  assign out_estimate       = est_r;
  assign out_minimum_recurs = recurs_out_r;
  assign out_from_secondary = fsec_r;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("word accepted during clearing pass");

  a_word_only_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (op_r == OP_QUERY))
    else $error("result word raised for an insert");

  a_source_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_minimum_recurs && out_from_secondary))
    else $error("recurring minimum taken from secondary table");

  a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(p_we || s_we))
    else $error("counter write while idle");
`endif

endmodule
